FILE: design/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int LEN_W    = 16;
    localparam int KEY_W    = 32;

    localparam logic [OPCODE_W-1:0] OPCODE_RESET = 4'h1;
    localparam logic [6:0]          LEN_CODE_16  = 7'd126;
    localparam logic [6:0]          LEN_CODE_64  = 7'd127;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXT     = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DROP    = 3'd5
    } phase_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              empty;
    } result_t;

endpackage

`default_nettype wire

FILE: design/wsd_parse.sv
// Header parser and payload unmasker: frame state plus one byte of work per step.
`timescale 1ns / 1ps
`default_nettype none

module wsd_parse
    import wsd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step,
    input  wire logic [BYTE_W-1:0]   rx_byte,
    input  wire logic                chunk_end,
    input  wire logic [OPCODE_W-1:0] accepted_opcode,
    output result_t                  result
);

    phase_t              phase_reg, phase_next;
    logic                accepted_reg, accepted_next;
    logic                mask_reg, mask_next;
    logic [LEN_W-1:0]    remaining_reg, remaining_next;
    logic [1:0]          hdr_cnt_reg, hdr_cnt_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [1:0]          key_idx_reg, key_idx_next;

    // next state
    always_comb begin
        logic [6:0] len7;
        len7           = rx_byte[6:0];
        phase_next     = phase_reg;
        accepted_next  = accepted_reg;
        mask_next      = mask_reg;
        remaining_next = remaining_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        key_next       = key_reg;
        key_idx_next   = key_idx_reg;
        case (phase_reg)
            PH_HDR0: begin
                key_next       = '0;
                key_idx_next   = '0;
                hdr_cnt_next   = '0;
                remaining_next = '0;
                mask_next      = 1'b0;
                if (rx_byte[OPCODE_W-1:0] == accepted_opcode) begin
                    accepted_next = 1'b1;
                    phase_next    = PH_HDR1;
                end else begin
                    accepted_next = 1'b0;
                    phase_next    = PH_DROP;
                end
            end
            PH_HDR1: begin
                mask_next = rx_byte[7];
                if (len7 == LEN_CODE_64) begin
                    accepted_next = 1'b0;
                    phase_next    = PH_DROP;
                end else if (len7 == LEN_CODE_16) begin
                    phase_next     = PH_EXT;
                    hdr_cnt_next   = '0;
                    remaining_next = '0;
                end else begin
                    remaining_next = {{(LEN_W-7){1'b0}}, len7};
                    if (rx_byte[7]) begin
                        phase_next   = PH_MASK;
                        hdr_cnt_next = '0;
                    end else if (len7 == 7'd0) begin
                        phase_next    = PH_DROP;
                        accepted_next = 1'b0;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_EXT: begin
                remaining_next = {remaining_reg[LEN_W-BYTE_W-1:0], rx_byte};
                if (hdr_cnt_reg != 2'd0) begin
                    if (mask_reg) begin
                        phase_next   = PH_MASK;
                        hdr_cnt_next = '0;
                    end else if (remaining_next == '0) begin
                        phase_next    = PH_DROP;
                        accepted_next = 1'b0;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end else begin
                    hdr_cnt_next = 2'd1;
                end
            end
            PH_MASK: begin
                // key bytes arrive lowest lane first
                key_next[{hdr_cnt_reg, 3'b000} +: BYTE_W] = rx_byte;
                if (hdr_cnt_reg == 2'd3) begin
                    if (remaining_reg == '0) begin
                        phase_next    = PH_DROP;
                        accepted_next = 1'b0;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end else begin
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                end
            end
            PH_PAYLOAD: begin
                key_idx_next   = key_idx_reg + 2'd1;
                remaining_next = remaining_reg - 1'b1;
                if (remaining_next == '0) begin
                    phase_next    = PH_DROP;
                    accepted_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
        // chunk end closes the frame whatever is left of it
        if (chunk_end) begin
            phase_next    = PH_HDR0;
            accepted_next = 1'b0;
        end
    end

    // result
    always_comb begin
        logic [6:0]        len7;
        logic [LEN_W-1:0]  ext_len;
        logic [BYTE_W-1:0] key_byte;
        logic              open_frame;
        len7         = rx_byte[6:0];
        ext_len      = {remaining_reg[LEN_W-BYTE_W-1:0], rx_byte};
        key_byte     = mask_reg ? key_reg[{key_idx_reg, 3'b000} +: BYTE_W] : '0;
        result       = '0;
        open_frame   = 1'b0;
        case (phase_reg)
            PH_HDR0: begin
                open_frame = 1'b0;
            end
            PH_HDR1: begin
                if (len7 != LEN_CODE_64 && len7 != LEN_CODE_16 && !rx_byte[7]
                        && len7 == 7'd0) begin
                    result.valid = 1'b1;
                    result.last  = 1'b1;
                    result.empty = 1'b1;
                end
                open_frame = accepted_reg && len7 != LEN_CODE_64;
            end
            PH_EXT: begin
                if (hdr_cnt_reg != 2'd0 && !mask_reg && ext_len == '0) begin
                    result.valid = 1'b1;
                    result.last  = 1'b1;
                    result.empty = 1'b1;
                end
                open_frame = accepted_reg;
            end
            PH_MASK: begin
                if (hdr_cnt_reg == 2'd3 && remaining_reg == '0) begin
                    result.valid = 1'b1;
                    result.last  = 1'b1;
                    result.empty = 1'b1;
                end
                open_frame = accepted_reg;
            end
            PH_PAYLOAD: begin
                result.valid = 1'b1;
                result.data  = rx_byte ^ key_byte;
                result.last  = (remaining_reg == {{(LEN_W-1){1'b0}}, 1'b1}) || chunk_end;
                open_frame   = accepted_reg;
            end
            default: begin
                open_frame = 1'b0;
            end
        endcase
        // header cut short by the chunk end: report an empty message
        if (chunk_end && !result.valid && open_frame) begin
            result.valid = 1'b1;
            result.last  = 1'b1;
            result.empty = 1'b1;
        end
        if (!step) begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HDR0;
            accepted_reg  <= 1'b0;
            mask_reg      <= 1'b0;
            remaining_reg <= '0;
            hdr_cnt_reg   <= '0;
            key_reg       <= '0;
            key_idx_reg   <= '0;
        end else if (step) begin
            phase_reg     <= phase_next;
            accepted_reg  <= accepted_next;
            mask_reg      <= mask_next;
            remaining_reg <= remaining_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            key_reg       <= key_next;
            key_idx_reg   <= key_idx_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/websocket_frame_deframer.sv
// WebSocket frame deframer top level: input register, parser, result register.
// An accepted byte passes through the input register and the parser into the result register, which drives m_*.
// Throughput: one byte per cycle while m_tready is high.
// A stalled result holds in the output register while the input register still fills.
// Reset (aresetn low, synchronous) empties both registers, returns the parser to the
// first header byte and sets the accepted opcode to 1.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] rx_byte
    input  wire logic                s_tlast,   // chunk_end
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [7:0]               m_tdata,   // [7:0] payload_byte
    output logic                     m_tlast,   // last_byte
    output logic                     m_tuser,   // [0] empty_message
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [OPCODE_W-1:0] cfg_data
);

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_end_reg;
    logic [OPCODE_W-1:0] opcode_reg;
    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_data_reg;
    logic                out_last_reg;
    logic                out_empty_reg;
    logic                advance;
    result_t             result;

    // the held request moves on once the output register can take a result
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opcode_reg <= OPCODE_RESET;
        end else if (cfg_valid) begin
            opcode_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    wsd_parse u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .rx_byte         (in_byte_reg),
        .chunk_end       (in_end_reg),
        .accepted_opcode (opcode_reg),
        .result          (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid && (!out_valid_reg || m_tready)) begin
            out_data_reg  <= result.data;
            out_last_reg  <= result.last;
            out_empty_reg <= result.empty;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the WebSocket frame deframer: directed and random chunks.
`timescale 1ns / 1ps

module tb_top;
    import wsd_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_BYTES   = 250;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
    } payload_exp_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;   // [7:0] rx_byte
    logic                s_tlast   = 1'b0; // chunk_end
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;          // [7:0] payload_byte
    logic                m_tlast;          // last_byte
    logic                m_tuser;          // [0] empty_message
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [OPCODE_W-1:0] cfg_data  = '0;

    // Deframer state as the checker sees it
    phase_t              ph;
    logic [OPCODE_W-1:0] opcode_sel;
    logic                accepting;
    logic                masked;
    logic [LEN_W-1:0]    remaining;
    logic [1:0]          hdr_cnt;
    logic [KEY_W-1:0]    key;
    logic [1:0]          key_idx;

    payload_exp_t expected_payload[$];

    bit steady_flow     = 1'b0;
    int errors          = 0;
    int results_checked = 0;
    int bytes_sent      = 0;
    int chunks_sent     = 0;
    int cycle_count     = 0;

    websocket_frame_deframer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_payload.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(0, 99) >= 9);
    end

    function automatic void push_result(input logic [7:0] d, input logic l, input logic e);
        payload_exp_t r;
        r.data  = d;
        r.last  = l;
        r.empty = e;
        expected_payload.push_back(r);
    endfunction

    // Header complete with a zero length gives one empty message
    function automatic bit start_payload();
        if (remaining == '0) begin
            ph        = PH_DROP;
            accepting = 1'b0;
            push_result(8'h00, 1'b1, 1'b1);
            return 1'b1;
        end
        ph = PH_PAYLOAD;
        return 1'b0;
    endfunction

    function automatic bit length_done();
        if (masked) begin
            ph      = PH_MASK;
            hdr_cnt = 2'd0;
            return 1'b0;
        end
        return start_payload();
    endfunction

    function automatic void predict_byte(input logic [7:0] rx, input logic chunk_end);
        bit         got;
        logic [7:0] v;
        logic [6:0] len7;
        got = 1'b0;
        case (ph)
            PH_HDR0: begin
                key       = '0;
                key_idx   = 2'd0;
                hdr_cnt   = 2'd0;
                remaining = '0;
                masked    = 1'b0;
                accepting = (rx[3:0] == opcode_sel);
                ph        = accepting ? PH_HDR1 : PH_DROP;
            end
            PH_HDR1: begin
                masked = rx[7];
                len7   = rx[6:0];
                if (len7 == LEN_CODE_64) begin
                    accepting = 1'b0;
                    ph        = PH_DROP;
                end else if (len7 == LEN_CODE_16) begin
                    ph        = PH_EXT;
                    hdr_cnt   = 2'd0;
                    remaining = '0;
                end else begin
                    remaining = {9'd0, len7};
                    got       = length_done();
                end
            end
            PH_EXT: begin
                remaining = {remaining[7:0], rx};
                if (hdr_cnt >= 2'd1) got = length_done();
                else hdr_cnt = 2'd1;
            end
            PH_MASK: begin
                key = key | (32'(rx) << (8 * hdr_cnt));
                if (hdr_cnt == 2'd3) got = start_payload();
                else hdr_cnt = hdr_cnt + 2'd1;
            end
            PH_PAYLOAD: begin
                v         = masked ? (rx ^ key[8 * key_idx +: 8]) : rx;
                key_idx   = key_idx + 2'd1;
                remaining = remaining - 1'b1;
                push_result(v, (remaining == '0) || chunk_end, 1'b0);
                got = 1'b1;
                if (remaining == '0) begin
                    ph        = PH_DROP;
                    accepting = 1'b0;
                end
            end
            default: ;
        endcase
        if (chunk_end) begin
            // A chunk cut short after the header started still closes the message
            if (!got && accepting && (ph == PH_EXT || ph == PH_MASK || ph == PH_PAYLOAD))
                push_result(8'h00, 1'b1, 1'b1);
            ph        = PH_HDR0;
            accepting = 1'b0;
        end
    endfunction

    always @(posedge aclk) begin : check_result
        payload_exp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_payload.size() == 0) begin
                $error("unexpected result: payload_byte %0h last_byte %0b empty_message %0b",
                       m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                want = expected_payload.pop_front();
                results_checked++;
                if (m_tdata !== want.data) begin
                    $error("payload_byte: expected %0h, got %0h", want.data, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_byte: expected %0b, got %0b", want.last, m_tlast);
                    errors++;
                end
                if (m_tuser !== want.empty) begin
                    $error("empty_message: expected %0b, got %0b", want.empty, m_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic chunk_end);
        while (!steady_flow && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= chunk_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_byte(b, chunk_end);
        bytes_sent++;
        if (chunk_end) chunks_sent++;
    endtask

    task automatic send_chunk(input logic [7:0] bytes[$]);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Drop valid and wait until every result is out and the pipeline is quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_payload.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_opcode(input logic [OPCODE_W-1:0] op);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= op;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        opcode_sel = op;
    endtask

    // Build one chunk: mostly a proper frame, sometimes with a tail or cut short
    task automatic send_frame(output int n);
        logic [7:0]          bytes[$];
        logic [OPCODE_W-1:0] op;
        logic                mask_bit;
        int                  plen;
        int                  sel;
        int                  cut;
        op       = ($urandom_range(0, 99) < 75) ? opcode_sel : OPCODE_W'($urandom);
        mask_bit = 1'($urandom);
        sel      = $urandom_range(0, 99);
        bytes.push_back({4'($urandom), op});
        if (sel < 85) begin
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 125) : $urandom_range(0, 20);
            bytes.push_back({mask_bit, 7'(plen)});
        end else if (sel < 96) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) plen = $urandom_range(256, 300);
            else if (sel == 1) plen = 16'($urandom);
            else plen = $urandom_range(0, 40);
            bytes.push_back({mask_bit, LEN_CODE_16});
            bytes.push_back(8'(plen >> 8));
            bytes.push_back(8'(plen));
            // huge lengths are always cut short by the chunk end
            if (plen > 300) plen = $urandom_range(0, 10);
        end else begin
            bytes.push_back({mask_bit, LEN_CODE_64});
            plen = $urandom_range(0, 8);
        end
        if (mask_bit)
            repeat (4) bytes.push_back(8'($urandom));
        repeat (plen) bytes.push_back(8'($urandom));
        sel = $urandom_range(0, 99);
        if (sel >= 70 && sel < 85) begin
            repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
        end else if (sel >= 85 && bytes.size() > 1) begin
            cut = $urandom_range(1, bytes.size() - 1);
            while (bytes.size() > cut) void'(bytes.pop_back());
        end
        n = bytes.size();
        send_chunk(bytes);
    endtask

    task automatic send_noise();
        logic [7:0] bytes[$];
        repeat ($urandom_range(1, 8)) bytes.push_back(8'($urandom));
        send_chunk(bytes);
    endtask

    task automatic run_random_frames(input int budget);
        int done;
        int n;
        done = 0;
        while (done < budget) begin
            if ($urandom_range(0, 99) < 80) begin
                send_frame(n);
                done += n;
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic test_directed_cases();
        // lone header byte, then a rejected opcode
        send_chunk('{8'h81});
        send_chunk('{8'h82, 8'h01, 8'hAA});
        // zero length, unmasked
        send_chunk('{8'h81, 8'h00});
        // masked, length 3, chunk cut after two payload bytes
        send_chunk('{8'h81, 8'h83, 8'hFF, 8'h00, 8'h5A, 8'hA5, 8'hFF, 8'h00});
        // 64-bit length code
        send_chunk('{8'h81, 8'h7F, 8'h00});
        // 16-bit length of one, trailing byte dropped
        send_chunk('{8'hF1, 8'h7E, 8'h00, 8'h01, 8'hFF, 8'h00});
        // chunk ends inside the extended length
        send_chunk('{8'h81, 8'hFE, 8'h00});
        settle();
    endtask

    task automatic test_opcode_extremes();
        write_opcode(4'h0);
        send_chunk('{8'hF0, 8'h01, 8'h7E});
        run_random_frames(PHASE_BYTES);
        write_opcode(4'hF);
        send_chunk('{8'h0F, 8'h80, 8'h01, 8'h02, 8'h03, 8'h04});
        run_random_frames(PHASE_BYTES);
    endtask

    task automatic test_random_opcode_steady();
        write_opcode(OPCODE_W'($urandom_range(2, 14)));
        steady_flow = 1'b1;
        run_random_frames(PHASE_BYTES);
        settle();
        steady_flow = 1'b0;
    endtask

    task automatic test_default_opcode();
        write_opcode(OPCODE_RESET);
        run_random_frames(PHASE_BYTES);
        settle();
    endtask

    initial begin
        ph         = PH_HDR0;
        opcode_sel = OPCODE_RESET;
        accepting  = 1'b0;
        masked     = 1'b0;
        remaining  = '0;
        hdr_cnt    = 2'd0;
        key        = '0;
        key_idx    = 2'd0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_opcode_extremes();
        test_random_opcode_steady();
        test_default_opcode();

        $display("summary: %0d bytes in %0d chunks, %0d results checked, %0d mismatches",
                 bytes_sent, chunks_sent, results_checked, errors);
        $display("summary: accepted opcodes 1, 0, 15 and one random, with and without stalls");
        if (errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
